// ===== rtl/cpde_pkg.sv =====
// shared types and constants of the chunk pad and delimit encoder
package cpde_pkg;

    // default upper bound on the chunk length
    localparam int DEFAULT_MAX_CHUNK_SIZE = 4096;
    // chunk length that still keeps a padding run inside 12 bits
    localparam int RUN_LIMIT = 4096;

    // configuration port geometry
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    // register indexes (byte address is 8 times the index)
    localparam logic [1:0] REG_CHUNK_SIZE          = 2'd0;
    localparam logic [1:0] REG_CHUNK_INDEX_LIMIT   = 2'd1;
    localparam logic [1:0] REG_MESSAGE_INDEX_LIMIT = 2'd2;

    // register reset values
    localparam logic [12:0] RST_CHUNK_SIZE          = 13'd256;
    localparam logic [31:0] RST_CHUNK_INDEX_LIMIT   = '1;
    localparam logic [63:0] RST_MESSAGE_INDEX_LIMIT = '1;

    // delimiter codes
    localparam logic [7:0] DELIM_MORE    = 8'd0;
    localparam logic [7:0] DELIM_FINAL   = 8'd1;
    localparam logic [7:0] DELIM_PADDED  = 8'd2;

    // padding byte choices
    localparam logic [7:0] PAD_AFTER_ZERO = 8'h01;
    localparam logic [7:0] PAD_DEFAULT    = 8'h00;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_PAD   = 2'd1,
        KIND_DELIM = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic [12:0] chunk_size;
        logic [31:0] chunk_index_limit;
        logic [63:0] message_index_limit;
    } cfg_t;

    // one result slot of a request's result group
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [11:0] run;
    } slot_t;

endpackage

// ===== rtl/chunk_pad_delimit_encoder_core.sv =====
// top level of the chunk pad and delimit encoder
//
//   channel   direction  handshake                  payload
//   input     in         in_valid / in_stall        data_byte, last_of_message
//   output    out        out_valid / out_stall      item_kind, byte_value, run_length,
//                                                   chunk_index, message_index, last_result
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// a request passes an input register, then one combinational step that builds its
// whole result group (0 to 3 results) into a group register. while the output does
// not stall, results leave one per cycle from the group register, so a request with n
// results holds the output until all are taken; one-result requests sustain one per cycle.
// reset clears counters, flags and all valid state; no clearing pass is needed.
// while the output stalls, one more request is taken into the input register.
module chunk_pad_delimit_encoder_core #(
    parameter int MAX_CHUNK_SIZE = cpde_pkg::DEFAULT_MAX_CHUNK_SIZE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            last_of_message,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      item_kind,
    output logic [7:0]                      byte_value,
    output logic [11:0]                     run_length,
    output logic [31:0]                     chunk_index,
    output logic [63:0]                     message_index,
    output logic                            last_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cpde_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cpde_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cpde_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int CS_TOP = (MAX_CHUNK_SIZE > cpde_pkg::RUN_LIMIT) ?
                            cpde_pkg::RUN_LIMIT : MAX_CHUNK_SIZE;

    cpde_pkg::cfg_t cfg;

    // input register
    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // message state
    logic [11:0] pos_reg,   pos_next;
    logic [31:0] chunk_reg, chunk_next;
    logic [63:0] msg_reg,   msg_next;
    logic        fail_reg,  fail_next;
    logic        drop_reg,  drop_next;

    // result group register
    logic [1:0]             cnt_reg, cnt_next;
    cpde_pkg::slot_t        slot_reg [3];
    cpde_pkg::slot_t        slot_next [3];
    logic [31:0]            tag_chunk_reg;
    logic [63:0]            tag_msg_reg;

    logic [12:0] cs_top;
    logic [12:0] cs_eff;
    logic [12:0] pos_inc;
    logic [11:0] pad_run;
    logic        over_limit;
    logic        take;
    logic        group_free;
    logic        move;
    logic        accept;

    cpde_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake control
    assign take       = (cnt_reg != 2'd0) && !out_stall;
    assign group_free = (cnt_reg == 2'd0) || (take && (cnt_reg == 2'd1));
    assign move       = in_vld_reg && group_free;
    assign in_stall   = in_vld_reg && !group_free;
    assign accept     = in_valid && !in_stall;

    // effective chunk length, clamped to the supported range
    assign cs_top = 13'(CS_TOP);
    always_comb
    begin
        if (cfg.chunk_size > cs_top)
            cs_eff = cs_top;
        else if (cfg.chunk_size < 13'd2)
            cs_eff = 13'd2;
        else
            cs_eff = cfg.chunk_size;
    end

    assign pos_inc    = {1'b0, pos_reg} + 13'd1;
    assign pad_run    = 12'(cs_eff - pos_inc);
    assign over_limit = (chunk_reg > cfg.chunk_index_limit) ||
                        (msg_reg > cfg.message_index_limit);

    // build the result group and next state for the request in the input register
    always_comb
    begin
        pos_next   = pos_reg;
        chunk_next = chunk_reg;
        msg_next   = msg_reg;
        fail_next  = fail_reg;
        drop_next  = drop_reg;
        cnt_next   = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            slot_next[i].kind  = cpde_pkg::KIND_ERROR;
            slot_next[i].value = 8'd0;
            slot_next[i].run   = 12'd0;
        end

        if (fail_reg)
        begin
            // sticky failure: one error per request
            cnt_next = 2'd1;
        end
        else if (drop_reg)
        begin
            // rest of a rejected message gives nothing
            if (in_last_reg)
            begin
                drop_next  = 1'b0;
                pos_next   = 12'd0;
                chunk_next = 32'd0;
            end
        end
        else if (over_limit)
        begin
            cnt_next = 2'd1;
            if (in_last_reg)
            begin
                pos_next   = 12'd0;
                chunk_next = 32'd0;
            end
            else
            begin
                drop_next = 1'b1;
            end
        end
        else
        begin
            slot_next[0].kind  = cpde_pkg::KIND_DATA;
            slot_next[0].value = in_byte_reg;
            slot_next[0].run   = 12'd1;
            if (in_last_reg)
            begin
                // close the message, padded unless it ends on a chunk boundary
                if (pos_inc < cs_eff)
                begin
                    cnt_next           = 2'd3;
                    slot_next[1].kind  = cpde_pkg::KIND_PAD;
                    slot_next[1].value = (in_byte_reg == 8'd0) ?
                                         cpde_pkg::PAD_AFTER_ZERO : cpde_pkg::PAD_DEFAULT;
                    slot_next[1].run   = pad_run;
                    slot_next[2].kind  = cpde_pkg::KIND_DELIM;
                    slot_next[2].value = cpde_pkg::DELIM_PADDED;
                    slot_next[2].run   = 12'd1;
                end
                else
                begin
                    cnt_next           = 2'd2;
                    slot_next[1].kind  = cpde_pkg::KIND_DELIM;
                    slot_next[1].value = cpde_pkg::DELIM_FINAL;
                    slot_next[1].run   = 12'd1;
                end
                if (msg_reg == '1)
                    fail_next = 1'b1;
                msg_next   = msg_reg + 64'd1;
                pos_next   = 12'd0;
                chunk_next = 32'd0;
            end
            else if (pos_inc >= cs_eff)
            begin
                // chunk full: delimiter, or error when the chunk counter is spent
                cnt_next = 2'd2;
                pos_next = 12'd0;
                if (chunk_reg == '1)
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    slot_next[1].kind  = cpde_pkg::KIND_DELIM;
                    slot_next[1].value = cpde_pkg::DELIM_MORE;
                    slot_next[1].run   = 12'd1;
                    chunk_next         = chunk_reg + 32'd1;
                end
            end
            else
            begin
                cnt_next = 2'd1;
                pos_next = pos_inc[11:0];
            end
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (accept)
            in_vld_reg <= 1'b1;
        else if (move)
            in_vld_reg <= 1'b0;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_of_message;
        end
    end

    // message state and group count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 12'd0;
            chunk_reg <= 32'd0;
            msg_reg   <= 64'd0;
            fail_reg  <= 1'b0;
            drop_reg  <= 1'b0;
            cnt_reg   <= 2'd0;
        end
        else if (move)
        begin
            pos_reg   <= pos_next;
            chunk_reg <= chunk_next;
            msg_reg   <= msg_next;
            fail_reg  <= fail_next;
            drop_reg  <= drop_next;
            cnt_reg   <= cnt_next;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // result group payload, shifted down as results leave
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            slot_reg[0]   <= slot_next[0];
            slot_reg[1]   <= slot_next[1];
            slot_reg[2]   <= slot_next[2];
            tag_chunk_reg <= chunk_reg;
            tag_msg_reg   <= msg_reg;
        end
        else if (take)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    // output fields
    assign out_valid     = (cnt_reg != 2'd0);
    assign item_kind     = slot_reg[0].kind;
    assign byte_value    = slot_reg[0].value;
    assign run_length    = slot_reg[0].run;
    assign chunk_index   = tag_chunk_reg;
    assign message_index = tag_msg_reg;
    assign last_result   = (cnt_reg == 2'd1);

endmodule

// ===== rtl/cpde_cfg_regs.sv =====
// configuration register file behind the apb-style port
module cpde_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cpde_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cpde_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cpde_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output cpde_pkg::cfg_t                  cfg
);

    logic [12:0] chunk_size_reg;
    logic [31:0] chunk_index_limit_reg;
    logic [63:0] message_index_limit_reg;
    logic [1:0]  reg_sel;
    logic        wr_en;

    assign reg_sel = paddr[4:3];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // register writes in the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_size_reg          <= cpde_pkg::RST_CHUNK_SIZE;
            chunk_index_limit_reg   <= cpde_pkg::RST_CHUNK_INDEX_LIMIT;
            message_index_limit_reg <= cpde_pkg::RST_MESSAGE_INDEX_LIMIT;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                cpde_pkg::REG_CHUNK_SIZE:
                    chunk_size_reg <= pwdata[12:0];
                cpde_pkg::REG_CHUNK_INDEX_LIMIT:
                    chunk_index_limit_reg <= pwdata[31:0];
                cpde_pkg::REG_MESSAGE_INDEX_LIMIT:
                    message_index_limit_reg <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    // read-back mux
    always_comb
    begin
        unique case (reg_sel)
            cpde_pkg::REG_CHUNK_SIZE:          prdata = {51'd0, chunk_size_reg};
            cpde_pkg::REG_CHUNK_INDEX_LIMIT:   prdata = {32'd0, chunk_index_limit_reg};
            cpde_pkg::REG_MESSAGE_INDEX_LIMIT: prdata = message_index_limit_reg;
            default:                           prdata = '0;
        endcase
    end

    assign cfg.chunk_size          = chunk_size_reg;
    assign cfg.chunk_index_limit   = chunk_index_limit_reg;
    assign cfg.message_index_limit = message_index_limit_reg;

endmodule
